>>> design/wrhs_pkg.sv
// Shared types, widths, codes and helpers for the win ratio histogram statistics block.
package wrhs_pkg;

   localparam int OP_W      = 2;
   localparam int WIN_W     = 32;
   localparam int SLOT_W    = 12;
   localparam int BIN_W     = 3;
   localparam int CNT_W     = 40;
   localparam int SUM_W     = 64;
   localparam int STAKE_W   = 16;
   localparam int THR_W     = 20;
   localparam int NUM_THR   = 6;
   localparam int CSR_IDX_W = 3;
   localparam int MED_W     = 12;
   localparam int MUL_W     = 32;

   localparam int PAYOUT_SLOTS_DEF = 4096;
   localparam int NUM_RANKS_DEF    = 6;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [BIN_W-1:0] NO_BIN  = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_STAKE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR5  = 3'd6;

   typedef enum logic [OP_W-1:0] {
      OP_RECORD    = 2'd0,
      OP_READ_RANK = 2'd1,
      OP_READ_SLOT = 2'd2,
      OP_READ_TOT  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_UPDATE,
      ST_XREAD,
      ST_WALK
   } state_type;

   // Reset values of the rank thresholds, in sixteenths of the stake.
   function automatic logic [THR_W-1:0] thr_reset(input int idx);
      logic [THR_W-1:0] val;
      case (idx)
         0:       val = 20'd0;
         1:       val = 20'd16;
         2:       val = 20'd32;
         3:       val = 20'd80;
         4:       val = 20'd160;
         default: val = 20'd800;
      endcase
      return val;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

endpackage

>>> design/win_ratio_histogram_stats.sv
// Win statistics accumulator: totals, rank bins, exact-value histogram and median walk.
//
// After reset the block clears its exact-value histogram memory, one entry a cycle,
// holding busy high meanwhile; configuration writes are taken at any time (csr_ready is
// always high). An operation is taken when start is high and busy is low, and its result
// appears for exactly one cycle with rsp_valid; it cannot be held off. A rank read is
// answered from the rank registers and an exact-value read through one registered memory
// read. A record uses one shared 32x32 multiplier to form stake times each rank threshold
// and then the squared win, one product a cycle, followed by the update state that also
// writes back the histogram entry of a non-zero win below PAYOUT_SLOTS, and the result
// follows in the next cycle. A totals read walks the histogram memory one entry a cycle
// through its read port, ending early once the median is found. The totals ports follow
// the stored totals at all times and are current in the cycle that rsp_valid is high.
module win_ratio_histogram_stats #(
   parameter int PAYOUT_SLOTS = wrhs_pkg::PAYOUT_SLOTS_DEF,
   parameter int NUM_RANKS    = wrhs_pkg::NUM_RANKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [wrhs_pkg::OP_W-1:0]         req_operation,
   input  logic [wrhs_pkg::WIN_W-1:0]        req_win_amount,
   input  logic [wrhs_pkg::SLOT_W-1:0]       req_slot_index,
   output logic                              rsp_valid,
   output logic [wrhs_pkg::BIN_W-1:0]        rsp_bin_number,
   output logic [wrhs_pkg::CNT_W-1:0]        rsp_bin_count,
   output logic [wrhs_pkg::SUM_W-1:0]        rsp_bin_win_sum,
   output logic [wrhs_pkg::CNT_W-1:0]        rsp_play_total,
   output logic [wrhs_pkg::SUM_W-1:0]        rsp_win_total,
   output logic [wrhs_pkg::SUM_W-1:0]        rsp_win_square_total,
   output logic [wrhs_pkg::CNT_W-1:0]        rsp_zero_win_total,
   output logic [wrhs_pkg::CNT_W-1:0]        rsp_large_win_total,
   output logic [wrhs_pkg::MED_W-1:0]        rsp_median_win,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wrhs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wrhs_pkg::THR_W-1:0]        csr_data
);
   import wrhs_pkg::*;

   localparam int AW    = $clog2(PAYOUT_SLOTS);
   localparam int CW    = AW + 1;
   localparam int RBINS = NUM_RANKS + 1;
   localparam int ACC_W = CNT_W + AW + 1;
   localparam int MC_W  = 3;

   // Configuration
   logic [STAKE_W-1:0] stake_ff;
   logic [THR_W-1:0]   thr_ff [NUM_THR];

   // Statistics state
   logic [CNT_W-1:0] exact_mem [PAYOUT_SLOTS];
   logic [CNT_W-1:0] rank_cnt_ff [RBINS];
   logic [SUM_W-1:0] rank_sum_ff [RBINS];
   logic [CNT_W-1:0] zero_cnt_ff, play_cnt_ff, large_cnt_ff;
   logic [SUM_W-1:0] win_sum_ff, win_sq_ff;

   // Sequencer and working registers
   state_type          state_ff, state_in;
   logic [WIN_W-1:0]   win_ff;
   logic [MC_W-1:0]    mul_cnt_ff;
   logic [2*MUL_W-1:0] prod_ff;
   logic [NUM_RANKS-1:0] above_ff;
   logic [CW-1:0]      seq_cnt_ff;
   logic               walk_vld_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [CNT_W-1:0]   rd_ff;

   // Result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]   rsp_bin_ff;
   logic [CNT_W-1:0]   rsp_cnt_ff;
   logic [SUM_W-1:0]   rsp_sum_ff;
   logic [MED_W-1:0]   rsp_med_ff;

   // Control decode
   logic             accept;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [CNT_W-1:0] mem_wdata;

   // Datapath helpers
   logic [STAKE_W-1:0]   stake_eff;
   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [WIN_W+3:0]     win16;
   logic                 win_small;
   logic [AW-1:0]        win_addr, slot_addr;
   logic [31:0]          slot_ext;
   logic                 slot_in_mem, slot_is_rank;
   logic [BIN_W-1:0]     pick;
   logic [CNT_W-1:0]     rank_cnt_new;
   logic [SUM_W-1:0]     rank_sum_new;
   logic [ACC_W-1:0]     acc_new;
   logic                 walk_hit, walk_last;
   logic [31:0]          walk_idx;

   function automatic logic [BIN_W-1:0] pick_bin(input logic [WIN_W-1:0] w,
                                                 input logic [NUM_RANKS-1:0] ab);
      logic [BIN_W-1:0] b;
      b = NO_BIN;
      if (w == '0) begin
         b = '0;
      end else if (ab[NUM_RANKS-1]) begin
         b = BIN_W'(NUM_RANKS);
      end else begin
         for (int k = NUM_RANKS - 1; k >= 1; k--) begin
            if (ab[k-1] && !ab[k]) begin
               b = BIN_W'(k);
            end
         end
      end
      return b;
   endfunction

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign stake_eff = (stake_ff == '0) ? STAKE_W'(1) : stake_ff;
   assign win16     = {win_ff, 4'b0000};
   assign win_small = (win_ff != '0) && ({1'b0, win_ff} < 33'(PAYOUT_SLOTS));
   assign win_addr  = win_ff[AW-1:0];
   assign slot_ext  = 32'(req_slot_index);
   assign slot_addr = slot_ext[AW-1:0];
   assign slot_in_mem  = (slot_ext < 32'(PAYOUT_SLOTS));
   assign slot_is_rank = (req_slot_index <= SLOT_W'(NUM_RANKS));

   // The shared multiplier forms stake times each threshold in turn, then the square.
   always_comb begin
      if (mul_cnt_ff < MC_W'(NUM_RANKS)) begin
         mul_a = MUL_W'(thr_ff[mul_cnt_ff]);
         mul_b = MUL_W'(stake_eff);
      end else begin
         mul_a = win_ff;
         mul_b = win_ff;
      end
   end

   assign pick         = pick_bin(win_ff, above_ff);
   assign rank_cnt_new = (pick == NO_BIN) ? '0 : sat_inc(rank_cnt_ff[pick]);
   assign rank_sum_new = (pick == NO_BIN) ? '0 : rank_sum_ff[pick] + SUM_W'(win_ff);

   assign acc_new   = acc_ff + ACC_W'(rd_ff);
   assign walk_hit  = walk_vld_ff && ({acc_new, 1'b0} >= (ACC_W + 1)'(play_cnt_ff));
   assign walk_last = walk_vld_ff && (seq_cnt_ff == CW'(PAYOUT_SLOTS));
   assign walk_idx  = 32'(seq_cnt_ff - 1'b1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (seq_cnt_ff == CW'(PAYOUT_SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_operation))
                  OP_RECORD:    state_in = ST_MUL;
                  OP_READ_SLOT: state_in = ST_XREAD;
                  OP_READ_TOT:  state_in = ST_WALK;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL: begin
            if (mul_cnt_ff == MC_W'(NUM_RANKS)) state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_XREAD:  state_in = ST_IDLE;
         ST_WALK: begin
            if (walk_hit || walk_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      mem_we       = 1'b0;
      mem_waddr    = win_addr;
      mem_wdata    = sat_inc(rd_ff);
      mem_raddr    = slot_addr;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = seq_cnt_ff[AW-1:0];
            mem_wdata = '0;
         end
         ST_IDLE: begin
            rsp_valid_in = accept && (op_type'(req_operation) == OP_READ_RANK);
         end
         ST_MUL:    mem_raddr = win_addr;
         ST_UPDATE: begin
            mem_we       = win_small;
            rsp_valid_in = 1'b1;
         end
         ST_XREAD:  rsp_valid_in = 1'b1;
         ST_WALK: begin
            mem_raddr    = seq_cnt_ff[AW-1:0];
            rsp_valid_in = walk_hit || walk_last;
         end
         default: begin
         end
      endcase
   end

   // Histogram memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         exact_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= exact_mem[mem_raddr];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stake_ff <= STAKE_W'(1);
         for (int i = 0; i < NUM_THR; i++) thr_ff[i] <= thr_reset(i);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_STAKE) begin
            stake_ff <= csr_data[STAKE_W-1:0];
         end else if (csr_index inside {[CSR_THR0:CSR_THR5]}) begin
            thr_ff[csr_index - CSR_THR0] <= csr_data;
         end
      end
   end

   // Sequencer, statistics and results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         seq_cnt_ff   <= '0;
         walk_vld_ff  <= 1'b0;
         mul_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         zero_cnt_ff  <= '0;
         play_cnt_ff  <= '0;
         large_cnt_ff <= '0;
         win_sum_ff   <= '0;
         win_sq_ff    <= '0;
         for (int i = 0; i < RBINS; i++) begin
            rank_cnt_ff[i] <= '0;
            rank_sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_CLEAR: seq_cnt_ff <= seq_cnt_ff + 1'b1;
            ST_IDLE: begin
               if (accept) begin
                  win_ff     <= req_win_amount;
                  mul_cnt_ff <= '0;
                  seq_cnt_ff <= '0;
                  // A slot read issues its memory read on this edge.
                  walk_vld_ff <= (op_type'(req_operation) == OP_READ_SLOT) && slot_in_mem;
                  acc_ff     <= ACC_W'(zero_cnt_ff);
                  if (op_type'(req_operation) == OP_READ_RANK) begin
                     rsp_med_ff   <= '0;
                     if (slot_is_rank) begin
                        rsp_bin_ff <= req_slot_index[BIN_W-1:0];
                        rsp_cnt_ff <= rank_cnt_ff[req_slot_index[BIN_W-1:0]];
                        rsp_sum_ff <= rank_sum_ff[req_slot_index[BIN_W-1:0]];
                     end else begin
                        rsp_bin_ff <= NO_BIN;
                        rsp_cnt_ff <= '0;
                        rsp_sum_ff <= '0;
                     end
                  end
               end
            end
            ST_MUL: begin
               prod_ff    <= mul_a * mul_b;
               mul_cnt_ff <= mul_cnt_ff + 1'b1;
               // The product formed in the previous cycle is compared here.
               if (mul_cnt_ff != '0) begin
                  above_ff[mul_cnt_ff - 1'b1] <= win16 > prod_ff[WIN_W+3:0];
               end
            end
            ST_UPDATE: begin
               play_cnt_ff <= sat_inc(play_cnt_ff);
               win_sum_ff  <= win_sum_ff + SUM_W'(win_ff);
               win_sq_ff   <= win_sq_ff + prod_ff;
               if (win_ff == '0) begin
                  zero_cnt_ff <= sat_inc(zero_cnt_ff);
               end else if (!win_small) begin
                  large_cnt_ff <= sat_inc(large_cnt_ff);
               end
               if (pick != NO_BIN) begin
                  rank_cnt_ff[pick] <= rank_cnt_new;
                  rank_sum_ff[pick] <= rank_sum_new;
               end
               rsp_bin_ff   <= pick;
               rsp_cnt_ff   <= rank_cnt_new;
               rsp_sum_ff   <= rank_sum_new;
               rsp_med_ff   <= '0;
            end
            ST_XREAD: begin
               rsp_bin_ff   <= NO_BIN;
               rsp_cnt_ff   <= walk_vld_ff ? rd_ff : '0;
               rsp_sum_ff   <= '0;
               rsp_med_ff   <= '0;
            end
            ST_WALK: begin
               // Reads are issued one entry ahead of the running sum.
               if (seq_cnt_ff != CW'(PAYOUT_SLOTS)) begin
                  seq_cnt_ff <= seq_cnt_ff + 1'b1;
               end
               walk_vld_ff <= (seq_cnt_ff != CW'(PAYOUT_SLOTS));
               if (walk_vld_ff) begin
                  acc_ff <= acc_new;
               end
               if (walk_hit || walk_last) begin
                  rsp_bin_ff   <= NO_BIN;
                  rsp_cnt_ff   <= '0;
                  rsp_sum_ff   <= '0;
                  rsp_med_ff   <= walk_hit ? walk_idx[MED_W-1:0] : '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bin_number       = rsp_bin_ff;
   assign rsp_bin_count        = rsp_cnt_ff;
   assign rsp_bin_win_sum      = rsp_sum_ff;
   assign rsp_median_win       = rsp_med_ff;
   assign rsp_play_total       = play_cnt_ff;
   assign rsp_win_total        = win_sum_ff;
   assign rsp_win_square_total = win_sq_ff;
   assign rsp_zero_win_total   = zero_cnt_ff;
   assign rsp_large_win_total  = large_cnt_ff;

endmodule

>>> verif/win_ratio_histogram_stats_tb.sv
// Self-checking testbench for the win ratio histogram statistics block.
`timescale 1ns / 1ps

module win_ratio_histogram_stats_tb;
   import wrhs_pkg::*;

   localparam int SLOTS       = PAYOUT_SLOTS_DEF;
   localparam int NRANK       = NUM_RANKS_DEF;
   localparam int QUIET_LIMIT = 20000;
   localparam logic [CSR_IDX_W-1:0] CSR_BEYOND = 3'd7;

   typedef struct packed {
      logic [BIN_W-1:0] bin_number;
      logic [CNT_W-1:0] bin_count;
      logic [SUM_W-1:0] bin_win_sum;
      logic [CNT_W-1:0] play_total;
      logic [SUM_W-1:0] win_total;
      logic [SUM_W-1:0] win_square_total;
      logic [CNT_W-1:0] zero_win_total;
      logic [CNT_W-1:0] large_win_total;
      logic [MED_W-1:0] median_win;
   } stats_word_type;

   typedef struct packed {
      op_type           op;
      logic [WIN_W-1:0] win;
      logic [SLOT_W-1:0] slot;
      logic             typed;
      stats_word_type   want;
   } drill_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OP_W-1:0]      req_operation;
   logic [WIN_W-1:0]     req_win_amount;
   logic [SLOT_W-1:0]    req_slot_index;
   logic                 rsp_valid;
   logic [BIN_W-1:0]     rsp_bin_number;
   logic [CNT_W-1:0]     rsp_bin_count;
   logic [SUM_W-1:0]     rsp_bin_win_sum;
   logic [CNT_W-1:0]     rsp_play_total;
   logic [SUM_W-1:0]     rsp_win_total;
   logic [SUM_W-1:0]     rsp_win_square_total;
   logic [CNT_W-1:0]     rsp_zero_win_total;
   logic [CNT_W-1:0]     rsp_large_win_total;
   logic [MED_W-1:0]     rsp_median_win;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [THR_W-1:0]     csr_data;

   // Predicted state of the block and its configuration.
   logic [CNT_W-1:0]   exact_hits [SLOTS];
   logic [CNT_W-1:0]   rank_hits [7];
   logic [SUM_W-1:0]   rank_wins [7];
   logic [CNT_W-1:0]   zero_plays;
   logic [CNT_W-1:0]   plays;
   logic [CNT_W-1:0]   large_plays;
   logic [SUM_W-1:0]   win_acc;
   logic [SUM_W-1:0]   square_acc;
   logic [STAKE_W-1:0] stake_cfg;
   logic [THR_W-1:0]   thr_cfg [NUM_THR];

   stats_word_type stats_due_q [$];
   drill_row_type  drill_q [$];
   int             fail_count = 0;
   int             quiet_cycles;

   win_ratio_histogram_stats i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_win_amount       (req_win_amount),
      .req_slot_index       (req_slot_index),
      .rsp_valid            (rsp_valid),
      .rsp_bin_number       (rsp_bin_number),
      .rsp_bin_count        (rsp_bin_count),
      .rsp_bin_win_sum      (rsp_bin_win_sum),
      .rsp_play_total       (rsp_play_total),
      .rsp_win_total        (rsp_win_total),
      .rsp_win_square_total (rsp_win_square_total),
      .rsp_zero_win_total   (rsp_zero_win_total),
      .rsp_large_win_total  (rsp_large_win_total),
      .rsp_median_win       (rsp_median_win),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CNT_W-1:0] bump40(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
   endfunction

   function automatic logic [SUM_W-1:0] stake_eff();
      return (stake_cfg == '0) ? 64'd1 : {48'd0, stake_cfg};
   endfunction

   // The ratio test is done as 16 * win against threshold * stake, so it stays exact.
   function automatic logic [BIN_W-1:0] rank_of(input logic [WIN_W-1:0] win);
      logic [SUM_W-1:0] st;
      logic [SUM_W-1:0] w16;
      logic [BIN_W-1:0] pick;
      int k;
      st = stake_eff();
      w16 = {28'd0, win, 4'd0};
      pick = NO_BIN;
      if (win == '0) begin
         pick = 3'd0;
      end else if (w16 > {44'd0, thr_cfg[NRANK-1]} * st) begin
         pick = BIN_W'(NRANK);
      end else begin
         for (k = 1; k < NRANK; k++) begin
            if (pick == NO_BIN && w16 > {44'd0, thr_cfg[k-1]} * st
                && !(w16 > {44'd0, thr_cfg[k]} * st)) begin
               pick = BIN_W'(k);
            end
         end
      end
      return pick;
   endfunction

   function automatic logic [MED_W-1:0] median_of();
      logic [SUM_W-1:0] acc;
      logic [MED_W-1:0] res;
      logic found;
      int i;
      acc = {24'd0, zero_plays};
      res = '0;
      found = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         if (!found) begin
            acc = acc + {24'd0, exact_hits[i]};
            if ((acc << 1) >= {24'd0, plays}) begin
               res = i[MED_W-1:0];
               found = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // Applies one operation to the predicted state and returns the word it should produce.
   function automatic stats_word_type predict_stats(input op_type op,
                                                    input logic [WIN_W-1:0] win,
                                                    input logic [SLOT_W-1:0] slot);
      stats_word_type w;
      logic [BIN_W-1:0] b;
      w = '0;
      w.bin_number = NO_BIN;
      case (op)
         OP_RECORD: begin
            if (win == '0) begin
               zero_plays = bump40(zero_plays);
            end else if (win < SLOTS) begin
               exact_hits[win[SLOT_W-1:0]] = bump40(exact_hits[win[SLOT_W-1:0]]);
            end else begin
               large_plays = bump40(large_plays);
            end
            plays = bump40(plays);
            win_acc = win_acc + {32'd0, win};
            square_acc = square_acc + {32'd0, win} * {32'd0, win};
            b = rank_of(win);
            if (b != NO_BIN) begin
               rank_hits[b] = bump40(rank_hits[b]);
               rank_wins[b] = rank_wins[b] + {32'd0, win};
               w.bin_number = b;
               w.bin_count = rank_hits[b];
               w.bin_win_sum = rank_wins[b];
            end
         end
         OP_READ_RANK: begin
            if (slot <= NRANK) begin
               w.bin_number = slot[BIN_W-1:0];
               w.bin_count = rank_hits[slot[BIN_W-1:0]];
               w.bin_win_sum = rank_wins[slot[BIN_W-1:0]];
            end
         end
         OP_READ_SLOT: begin
            if (slot < SLOTS) w.bin_count = exact_hits[slot];
         end
         default: begin
            w.median_win = median_of();
         end
      endcase
      w.play_total = plays;
      w.win_total = win_acc;
      w.win_square_total = square_acc;
      w.zero_win_total = zero_plays;
      w.large_win_total = large_plays;
      return w;
   endfunction

   function automatic stats_word_type mk_word(
      input logic [BIN_W-1:0] bnum, input logic [CNT_W-1:0] bcnt, input logic [SUM_W-1:0] bsum,
      input logic [CNT_W-1:0] play, input logic [SUM_W-1:0] wsum, input logic [SUM_W-1:0] sq,
      input logic [CNT_W-1:0] zero, input logic [CNT_W-1:0] big, input logic [MED_W-1:0] med);
      stats_word_type w;
      w.bin_number = bnum;
      w.bin_count = bcnt;
      w.bin_win_sum = bsum;
      w.play_total = play;
      w.win_total = wsum;
      w.win_square_total = sq;
      w.zero_win_total = zero;
      w.large_win_total = big;
      w.median_win = med;
      return w;
   endfunction

   task automatic add_row(input op_type op, input logic [WIN_W-1:0] win,
                          input logic [SLOT_W-1:0] slot, input logic typed,
                          input stats_word_type want);
      drill_row_type r;
      r.op = op;
      r.win = win;
      r.slot = slot;
      r.typed = typed;
      r.want = want;
      drill_q = {drill_q, r};
   endtask

   // Win amounts biased towards the current rank boundaries and the histogram range.
   function automatic logic [WIN_W-1:0] pick_win();
      logic [SUM_W-1:0] v;
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         v = '0;
      end else if (roll < 38) begin
         v = SUM_W'($urandom_range(1, 200));
      end else if (roll < 63) begin
         v = (({44'd0, thr_cfg[$urandom_range(NUM_THR-1)]} * stake_eff()) >> 4)
             + SUM_W'($urandom_range(4));
         v = (v < 64'd2) ? 64'd0 : v - 64'd2;
         if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      end else if (roll < 78) begin
         v = SUM_W'($urandom_range(1, SLOTS - 1));
      end else if (roll < 92) begin
         v = SUM_W'($urandom());
      end else begin
         case ($urandom_range(3))
            0:       v = SUM_W'(SLOTS - 1);
            1:       v = SUM_W'(SLOTS);
            2:       v = 64'hFFFF_FFFF;
            default: v = 64'd1;
         endcase
      end
      return v[WIN_W-1:0];
   endfunction

   task automatic issue(input op_type op, input logic [WIN_W-1:0] win,
                        input logic [SLOT_W-1:0] slot, input logic typed,
                        input stats_word_type want);
      stats_word_type guess;
      start <= 1'b1;
      req_operation <= op;
      req_win_amount <= win;
      req_slot_index <= slot;
      do @(posedge clock); while (busy);
      guess = predict_stats(op, win, slot);
      stats_due_q = {stats_due_q, (typed ? want : guess)};
   endtask

   // Holds the sender off until every outstanding word has come back and the block is idle.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (stats_due_q.size() != 0 || busy);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_STAKE) begin
         stake_cfg = data[STAKE_W-1:0];
      end else if (idx inside {[CSR_THR0:CSR_THR5]}) begin
         thr_cfg[idx - CSR_THR0] = data;
      end
   endtask

   task automatic set_config(input logic [THR_W-1:0] st,
                             input logic [THR_W-1:0] t0, input logic [THR_W-1:0] t1,
                             input logic [THR_W-1:0] t2, input logic [THR_W-1:0] t3,
                             input logic [THR_W-1:0] t4, input logic [THR_W-1:0] t5);
      logic [THR_W-1:0] t [NUM_THR];
      int k;
      t[0] = t0;
      t[1] = t1;
      t[2] = t2;
      t[3] = t3;
      t[4] = t4;
      t[5] = t5;
      csr_write(CSR_STAKE, st);
      for (k = 0; k < NUM_THR; k++) begin
         csr_write(CSR_IDX_W'(CSR_THR0 + k), t[k]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count, input logic idle_on);
      op_type op;
      logic [WIN_W-1:0] win;
      logic [SLOT_W-1:0] slot;
      int roll;
      int n;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         win = $urandom();
         slot = SLOT_W'($urandom_range(SLOTS - 1));
         if (roll < 70) begin
            op = OP_RECORD;
            win = pick_win();
         end else if (roll < 82) begin
            op = OP_READ_RANK;
            if ($urandom_range(9) != 0) slot = SLOT_W'($urandom_range(7));
         end else if (roll < 94) begin
            op = OP_READ_SLOT;
            if ($urandom_range(1) != 0) slot = SLOT_W'($urandom_range(200));
         end else begin
            op = OP_READ_TOT;
         end
         if (idle_on && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         if (stats_due_q.size() != 0 && $urandom_range(199) == 0) drain();
         issue(op, win, slot, 1'b0, '0);
      end
   endtask

   task automatic report_mismatch(input string field, input logic [SUM_W-1:0] got,
                                  input logic [SUM_W-1:0] want);
      $display("MISMATCH at %0t: %s is 0x%0h, expected 0x%0h", $time, field, got, want);
      fail_count++;
   endtask

   // Every word is taken in the cycle its strobe is high and checked against the oldest
   // expectation.
   always @(posedge clock) begin
      stats_word_type want;
      if (!reset && rsp_valid) begin
         if (stats_due_q.size() == 0) begin
            report_mismatch("unexpected word, bin_number", SUM_W'(rsp_bin_number),
                            SUM_W'(NO_BIN));
         end else begin
            want = stats_due_q.pop_front();
            if (rsp_bin_number !== want.bin_number)
               report_mismatch("bin_number", SUM_W'(rsp_bin_number),
                               SUM_W'(want.bin_number));
            if (rsp_bin_count !== want.bin_count)
               report_mismatch("bin_count", SUM_W'(rsp_bin_count), SUM_W'(want.bin_count));
            if (rsp_bin_win_sum !== want.bin_win_sum)
               report_mismatch("bin_win_sum", rsp_bin_win_sum, want.bin_win_sum);
            if (rsp_play_total !== want.play_total)
               report_mismatch("play_total", SUM_W'(rsp_play_total), SUM_W'(want.play_total));
            if (rsp_win_total !== want.win_total)
               report_mismatch("win_total", rsp_win_total, want.win_total);
            if (rsp_win_square_total !== want.win_square_total)
               report_mismatch("win_square_total", rsp_win_square_total,
                               want.win_square_total);
            if (rsp_zero_win_total !== want.zero_win_total)
               report_mismatch("zero_win_total", SUM_W'(rsp_zero_win_total),
                               SUM_W'(want.zero_win_total));
            if (rsp_large_win_total !== want.large_win_total)
               report_mismatch("large_win_total", SUM_W'(rsp_large_win_total),
                               SUM_W'(want.large_win_total));
            if (rsp_median_win !== want.median_win)
               report_mismatch("median_win", SUM_W'(rsp_median_win),
                               SUM_W'(want.median_win));
         end
      end
   end

   // The clearing pass after reset and a full median walk are the longest quiet spells.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("win_ratio_histogram_stats verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [THR_W-1:0] walk_t [NUM_THR];
      logic [THR_W-1:0] walk_sum;
      int k;
      reset <= 1'b1;
      start <= 1'b0;
      req_operation <= OP_RECORD;
      req_win_amount <= '0;
      req_slot_index <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_STAKE;
      csr_data <= '0;

      for (k = 0; k < SLOTS; k++) exact_hits[k] = '0;
      for (k = 0; k < 7; k++) begin
         rank_hits[k] = '0;
         rank_wins[k] = '0;
      end
      zero_plays = '0;
      plays = '0;
      large_plays = '0;
      win_acc = '0;
      square_acc = '0;
      stake_cfg = 16'd1;
      thr_cfg[0] = 20'd0;
      thr_cfg[1] = 20'd16;
      thr_cfg[2] = 20'd32;
      thr_cfg[3] = 20'd80;
      thr_cfg[4] = 20'd160;
      thr_cfg[5] = 20'd800;

      // Reads straight after reset, the out-of-range rank reads, and the first few records
      // under the reset thresholds have results that can be written down directly.
      add_row(OP_READ_TOT, 32'd0, 12'd0, 1'b1, mk_word(NO_BIN, '0, '0, '0, '0, '0, '0, '0, '0));
      add_row(OP_READ_RANK, 32'd0, 12'd0, 1'b1, mk_word(3'd0, '0, '0, '0, '0, '0, '0, '0, '0));
      add_row(OP_READ_RANK, 32'hFFFF_FFFF, 12'd7, 1'b1,
              mk_word(NO_BIN, '0, '0, '0, '0, '0, '0, '0, '0));
      add_row(OP_READ_RANK, 32'd0, 12'hFFF, 1'b1,
              mk_word(NO_BIN, '0, '0, '0, '0, '0, '0, '0, '0));
      add_row(OP_READ_SLOT, 32'd0, 12'd0, 1'b1, mk_word(NO_BIN, '0, '0, '0, '0, '0, '0, '0, '0));
      add_row(OP_RECORD, 32'd0, 12'hFFF, 1'b1,
              mk_word(3'd0, 40'd1, '0, 40'd1, '0, '0, 40'd1, '0, '0));
      add_row(OP_RECORD, 32'd1, 12'd0, 1'b1,
              mk_word(3'd1, 40'd1, 64'd1, 40'd2, 64'd1, 64'd1, 40'd1, '0, '0));
      add_row(OP_RECORD, 32'd2, 12'd0, 1'b1,
              mk_word(3'd2, 40'd1, 64'd2, 40'd3, 64'd3, 64'd5, 40'd1, '0, '0));
      add_row(OP_RECORD, 32'd3, 12'd0, 1'b0, '0);
      add_row(OP_RECORD, 32'd5, 12'd0, 1'b0, '0);
      add_row(OP_RECORD, 32'd6, 12'd0, 1'b0, '0);
      add_row(OP_RECORD, 32'd10, 12'd0, 1'b0, '0);
      add_row(OP_RECORD, 32'd11, 12'd0, 1'b0, '0);
      add_row(OP_RECORD, 32'd50, 12'd0, 1'b0, '0);
      add_row(OP_RECORD, 32'd51, 12'd0, 1'b0, '0);
      add_row(OP_RECORD, WIN_W'(SLOTS - 1), 12'd0, 1'b0, '0);
      add_row(OP_RECORD, WIN_W'(SLOTS), 12'd0, 1'b0, '0);
      // Two maximum wins make the squared total wrap.
      add_row(OP_RECORD, 32'hFFFF_FFFF, 12'hFFF, 1'b0, '0);
      add_row(OP_RECORD, 32'hFFFF_FFFF, 12'd0, 1'b0, '0);
      add_row(OP_READ_RANK, 32'd0, 12'd1, 1'b0, '0);
      add_row(OP_READ_RANK, 32'd0, 12'd3, 1'b0, '0);
      add_row(OP_READ_RANK, 32'd0, SLOT_W'(NRANK), 1'b0, '0);
      add_row(OP_READ_SLOT, 32'd0, 12'd2, 1'b0, '0);
      add_row(OP_READ_SLOT, 32'hFFFF_FFFF, 12'hFFF, 1'b0, '0);
      add_row(OP_READ_TOT, 32'hFFFF_FFFF, 12'hFFF, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_q[r]) begin
         if ($urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         issue(drill_q[r].op, drill_q[r].win, drill_q[r].slot, drill_q[r].typed,
               drill_q[r].want);
      end
      run_random(220, 1'b1);

      // A zero stake behaves as a stake of one.
      drain();
      set_config(20'd0, 20'd3, 20'd8, 20'd24, 20'd48, 20'd200, 20'd1000);
      run_random(220, 1'b1);

      // Largest stake and widest thresholds, sent back to back with no idling.
      drain();
      set_config(20'd65535, 20'd0, 20'd1, 20'd2, 20'd16, 20'd4096, 20'hFFFFF);
      run_random(220, 1'b0);

      // Thresholds out of order leave some ratios with no bin.
      drain();
      set_config(20'd7, 20'd100, 20'd50, 20'd200, 20'd150, 20'd400, 20'd300);
      run_random(220, 1'b1);

      // A write beyond the last register, which the block ignores, is driven ahead of new thresholds.
      drain();
      walk_sum = '0;
      for (k = 0; k < NUM_THR; k++) begin
         walk_sum = walk_sum + THR_W'($urandom_range(400));
         walk_t[k] = walk_sum;
      end
      csr_write(CSR_BEYOND, THR_W'($urandom_range(20'hFFFFF)));
      set_config(THR_W'($urandom_range(1, 300)), walk_t[0], walk_t[1], walk_t[2], walk_t[3],
                 walk_t[4], walk_t[5]);
      run_random(220, 1'b1);

      // Every threshold at its maximum: only the zero bin and the top bin can be hit.
      drain();
      set_config(20'd1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      run_random(225, 1'b1);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("win_ratio_histogram_stats verification clean");
      end else begin
         $display("win_ratio_histogram_stats verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
design/wrhs_pkg.sv
design/win_ratio_histogram_stats.sv
verif/win_ratio_histogram_stats_tb.sv
